// ===== rtl/core/ic4k_pkg.sv =====
// ----------------------------------------------------------------------------
// ic4k_pkg
// Shared types and constants of the four-kernel 3x3 image convolution filter.
// ----------------------------------------------------------------------------
package ic4k_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int CFG_SIZE_W = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int SUM_W      = 14;
    localparam int QUO_W      = 13;
    localparam int DIVR_W     = 10;
    localparam int DIV_STEPS  = QUO_W;
    localparam int STEP_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 2'd3;

    localparam logic [1:0] MODE_GAUSS   = 2'd0;
    localparam logic [1:0] MODE_EMBOSS  = 2'd1;
    localparam logic [1:0] MODE_AVERAGE = 2'd2;
    localparam logic [1:0] MODE_HLINE   = 2'd3;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       frame_start;
    } t_in_word;

    typedef struct packed {
        logic [9:0] out_row;
        logic [9:0] out_col;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_end;
    } t_out_word;

    typedef struct packed {
        logic capture;
        logic compute;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic use_div;
    } t_status;

endpackage

// ===== rtl/core/ic4k_ctrl.sv =====
// ----------------------------------------------------------------------------
// ic4k_ctrl
// Sequencer: takes a word, reads the line stores, divides, presents result.
// ----------------------------------------------------------------------------
module ic4k_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  ic4k_pkg::t_status i_status,
    output ic4k_pkg::t_cmd    o_cmd
);
    import ic4k_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_LOAD = 3'd3;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.compute = 1'b1;
                n_step = '0;
                if (!i_status.emit) begin
                    n_state = ST_IDLE;
                end else if (i_status.use_div) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_LOAD;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // The output register takes the new word once it is empty or
                // its current word leaves at this edge.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/ic4k_dp.sv =====
// ----------------------------------------------------------------------------
// ic4k_dp
// Datapath: settings, position counters, line stores, window, kernel sums,
// a bit-serial divider per plane and the result register.
// ----------------------------------------------------------------------------
module ic4k_dp #(
    parameter int MAX_WIDTH  = ic4k_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ic4k_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ic4k_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ic4k_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  ic4k_pkg::t_in_word                  i_in,
    input  ic4k_pkg::t_cmd                      i_cmd,
    output ic4k_pkg::t_status                   o_status,
    output ic4k_pkg::t_out_word                 o_out
);
    import ic4k_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int MW  = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                         $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
    localparam int LW  = (MW > CFG_SIZE_W) ? MW + 1 : CFG_SIZE_W + 1;

    // Settings.
    logic [1:0]            r_mode;
    logic [DIVR_W-1:0]     r_divisor;
    logic [CFG_SIZE_W-1:0] r_width;
    logic [CFG_SIZE_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_GAUSS;
            r_divisor <= DIVR_W'(1);
            r_width   <= CFG_SIZE_W'(1024);
            r_height  <= CFG_SIZE_W'(1024);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MODE:    r_mode    <= i_cfg_data[1:0];
                REG_DIVISOR: r_divisor <= i_cfg_data[DIVR_W-1:0];
                REG_WIDTH:   r_width   <= i_cfg_data[CFG_SIZE_W-1:0];
                REG_HEIGHT:  r_height  <= i_cfg_data[CFG_SIZE_W-1:0];
                default:     r_mode    <= r_mode;
            endcase
        end
    end

    logic [LW-1:0]     lim_w, lim_h;
    logic [DIVR_W-1:0] div_eff;

    always_comb begin
        lim_w = LW'(r_width);
        if (r_width == '0) begin
            lim_w = LW'(1);
        end else if (LW'(r_width) > LW'(MAX_WIDTH)) begin
            lim_w = LW'(MAX_WIDTH);
        end
        lim_h = LW'(r_height);
        if (r_height == '0) begin
            lim_h = LW'(1);
        end else if (LW'(r_height) > LW'(MAX_HEIGHT)) begin
            lim_h = LW'(MAX_HEIGHT);
        end
        div_eff = (r_divisor == '0) ? DIVR_W'(1) : r_divisor;
    end

    // Captured word and position.
    logic [23:0]   r_px;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] cur_col;
    logic [RW-1:0] cur_row;

    assign cur_col = i_in.frame_start ? '0 : r_col;
    assign cur_row = i_in.frame_start ? '0 : r_row;

    // Line stores: read on capture, written on compute.
    logic [23:0] mem_up [MAX_WIDTH];
    logic [23:0] mem_lo [MAX_WIDTH];
    logic [23:0] r_up, r_lo;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_up <= mem_up[cur_col];
        end
        if (i_cmd.compute) begin
            mem_up[r_col] <= r_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_lo <= mem_lo[cur_col];
        end
        if (i_cmd.compute) begin
            mem_lo[r_col] <= r_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_px <= {i_in.blue_in, i_in.green_in, i_in.red_in};
        end
    end

    // Window: entries 0..2 one column left, 3..5 two columns left.
    logic [23:0] r_win [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_cmd.compute) begin
            r_win[3] <= r_win[0];
            r_win[4] <= r_win[1];
            r_win[5] <= r_win[2];
            r_win[0] <= r_up;
            r_win[1] <= r_lo;
            r_win[2] <= r_px;
        end
    end

    // Position counters advance once the word's window is used.
    logic [LW-1:0] col_inc, row_inc;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;

    always_comb begin
        col_inc = LW'(r_col) + LW'(1);
        row_inc = LW'(r_row) + LW'(1);
        n_col   = CW'(col_inc);
        n_row   = r_row;
        if (col_inc >= lim_w) begin
            n_col = '0;
            n_row = (row_inc >= lim_h) ? '0 : RW'(row_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.capture) begin
            r_col <= cur_col;
            r_row <= cur_row;
        end else if (i_cmd.compute) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_status.emit = (LW'(r_row) >= LW'(2)) && (LW'(r_col) >= LW'(2)) &&
                           (LW'(r_row) < lim_h) && (LW'(r_col) < lim_w);
    assign o_status.use_div = (r_mode == MODE_GAUSS) || (r_mode == MODE_AVERAGE);

    // Per-plane kernel sum, divider and clamp.
    logic [9:0] r_orow, r_ocol;
    logic       r_oend;

    always_ff @(posedge i_clk) begin
        if (i_cmd.compute) begin
            r_orow <= 10'(32'(r_row) - 32'd1);
            r_ocol <= 10'(32'(r_col) - 32'd1);
            r_oend <= (LW'(r_row) == lim_h - LW'(1)) && (LW'(r_col) == lim_w - LW'(1));
        end
    end

    for (genvar p = 0; p < 3; p++) begin : g_plane
        logic signed [SUM_W-1:0] p00, p01, p02, p10, p11, p12, p20, p21, p22;
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] r_sum;
        logic [QUO_W-1:0]        r_q;
        logic [DIVR_W-1:0]       r_rem;
        logic [DIVR_W:0]         rem_sh;
        logic [7:0]              res;

        assign p00 = $signed(SUM_W'(r_win[3][8*p +: 8]));
        assign p10 = $signed(SUM_W'(r_win[4][8*p +: 8]));
        assign p20 = $signed(SUM_W'(r_win[5][8*p +: 8]));
        assign p01 = $signed(SUM_W'(r_win[0][8*p +: 8]));
        assign p11 = $signed(SUM_W'(r_win[1][8*p +: 8]));
        assign p21 = $signed(SUM_W'(r_win[2][8*p +: 8]));
        assign p02 = $signed(SUM_W'(r_up[8*p +: 8]));
        assign p12 = $signed(SUM_W'(r_lo[8*p +: 8]));
        assign p22 = $signed(SUM_W'(r_px[8*p +: 8]));

        always_comb begin
            case (r_mode)
                MODE_GAUSS:   sum = ((p01 + p10 + p12 + p21) <<< 2) + (p11 <<< 3);
                MODE_EMBOSS:  sum = p00 + p01 - p02 + p10 + p11 - p12 + p20 - p21 - p22;
                MODE_AVERAGE: sum = p00 + p01 + p02 + p10 + p11 + p12 + p20 + p21 + p22;
                default:      sum = p20 + (p21 <<< 1) + p22 - p00 - (p01 <<< 1) - p02;
            endcase
        end

        assign rem_sh = {r_rem, r_q[QUO_W-1]};

        // Restoring division, one quotient bit per step.
        always_ff @(posedge i_clk) begin
            if (i_cmd.compute) begin
                r_sum <= sum;
                r_q   <= sum[QUO_W-1:0];
                r_rem <= '0;
            end else if (i_cmd.div_step) begin
                if (rem_sh >= {1'b0, div_eff}) begin
                    r_rem <= DIVR_W'(rem_sh - {1'b0, div_eff});
                    r_q   <= {r_q[QUO_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[DIVR_W-1:0];
                    r_q   <= {r_q[QUO_W-2:0], 1'b0};
                end
            end
        end

        always_comb begin
            if (o_status.use_div) begin
                res = (r_q > QUO_W'(255)) ? 8'd255 : r_q[7:0];
            end else if (r_sum < 0) begin
                res = 8'd0;
            end else if (r_sum > SUM_W'(255)) begin
                res = 8'd255;
            end else begin
                res = r_sum[7:0];
            end
        end
    end

    t_out_word r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.out_row   <= r_orow;
            r_out.out_col   <= r_ocol;
            r_out.red_out   <= g_plane[0].res;
            r_out.green_out <= g_plane[1].res;
            r_out.blue_out  <= g_plane[2].res;
            r_out.frame_end <= r_oend;
        end
    end

    assign o_out = r_out;

endmodule

// ===== rtl/core/image_conv3x3_four_kernels.sv =====
// ----------------------------------------------------------------------------
// image_conv3x3_four_kernels
// 3x3 convolution (gauss, emboss, average, horizontal line) over RGB pixels.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order as words on the input channel; frame_start
// marks row 0, column 0. For every interior pixel one word leaves on the
// output channel, carrying its row, column and the three clamped planes,
// once its lower-right neighbor has been taken. Border pixels give no word.
// Settings must be written on the configuration channel only while the
// block is idle, which the block does not enforce; its ready is always high.
// One input word is worked on at a time: a word that gives no result only
// passes the idle and read states; emboss and horizontal line then go to the
// load state, while gauss and average first run the 13-step bit-serial
// divider before it. The output word is valid in the cycle after loading.
// The output word sits in one output register until the receiver takes it;
// the next input word is taken meanwhile, and its result waits in the
// datapath while the sequencer holds in its load state until that register
// frees. Reset returns the settings to their defaults, clears the window,
// the position and the output valid; line stores are not cleared.
module image_conv3x3_four_kernels #(
    parameter int MAX_WIDTH  = ic4k_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ic4k_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  ic4k_pkg::t_in_word              i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output ic4k_pkg::t_out_word             o_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ic4k_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ic4k_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ic4k_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    ic4k_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ic4k_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out       (o_out)
    );

endmodule
